### rtl/cdds_pkg.sv
// types, codes and calendar helpers for the date stepper
package cdds_pkg;

  typedef logic [1:0]         cmd_t;
  typedef logic [1:0]         status_t;
  typedef logic [4:0]         day_t;
  typedef logic [3:0]         month_t;
  typedef logic signed [15:0] year_t;

  localparam cmd_t CMD_LOAD = 2'd0;
  localparam cmd_t CMD_NEXT = 2'd1;
  localparam cmd_t CMD_PREV = 2'd2;
  localparam cmd_t CMD_NONE = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_LOAD = 2'd1;
  localparam status_t ST_LIMIT    = 2'd2;

  localparam year_t YEAR_MAX = 16'sh7fff;
  localparam year_t YEAR_MIN = 16'sh8000;

  localparam day_t   RESET_DAY   = 5'd25;
  localparam month_t RESET_MONTH = 4'd12;
  localparam year_t  RESET_YEAR  = 16'sd1;

  localparam month_t MONTH_DEC = 4'd12;
  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;

  // divisibility by 25 of a 16 bit value: 1024 = -1 mod 25, so fold the top bits
  // down; the offset of 63 keeps the sum positive and moves the residue to 13
  function automatic logic div25(input logic [15:0] a);
    logic [10:0] t;
    logic        hit;
    t   = {1'b0, a[9:0]} + 11'd63 - {5'b0, a[15:10]};
    hit = 1'b0;
    for (int i = 0; i < 44; i++) begin
      if (t == 11'(25 * i + 13)) hit = 1'b1;
    end
    return hit;
  endfunction

  // gregorian leap test; years before 1 ad are shifted up by one
  function automatic logic is_leap(input year_t year);
    year_t       y;
    logic [15:0] mag;
    y   = (year < 16'sd1) ? year + 16'sd1 : year;
    mag = y[15] ? 16'(-y) : 16'(y);
    return (y[1:0] == 2'b00) && (!div25(mag) || (y[3:0] == 4'b0000));
  endfunction

  // month length, zero for a month number outside 1 to 12
  function automatic day_t month_len(input month_t month, input logic leap);
    day_t len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### rtl/calendar_date_day_stepper.sv
// date stepper top level: command decode, date update and output skid buffer
//
// Keeps one proleptic gregorian date (day, month, signed year, no year zero;
// reset gives 25 december 1 ad) and answers every command word with one result
// word holding the date after the command and a status. Load checks the date
// and rejects bad ones with status 1; next day and previous day step the date
// and hold it with status 2 at the ends of the 16 bit year range. Leap test,
// month length lookup and date update are combinational between the input
// port and the result register; a new word can be taken on every cycle while
// in_stall is low. A two entry output buffer lets one word be accepted while
// a result waits on a stalled output; in_stall rises only when both are full.
module calendar_date_day_stepper (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cdds_pkg::cmd_t          command,
  input  cdds_pkg::day_t          load_day,
  input  cdds_pkg::month_t        load_month,
  input  cdds_pkg::year_t         load_year,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cdds_pkg::day_t          cur_day,
  output cdds_pkg::month_t        cur_month,
  output cdds_pkg::year_t         cur_year,
  output cdds_pkg::status_t       status
);

  typedef struct packed {
    cdds_pkg::day_t    day;
    cdds_pkg::month_t  month;
    cdds_pkg::year_t   year;
    cdds_pkg::status_t status;
  } result_t;

  cdds_pkg::day_t   day_reg,   day_next;
  cdds_pkg::month_t month_reg, month_next;
  cdds_pkg::year_t  year_reg,  year_next;
  cdds_pkg::status_t st_next;

  result_t out_word, skid_word, res;
  logic    skid_valid;
  logic    accept;
  logic    load_ok;
  logic    leap_load, leap_cur;
  cdds_pkg::day_t   len_load, len_cur, len_prev_month;
  cdds_pkg::month_t prev_month;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;

  assign leap_load      = cdds_pkg::is_leap(load_year);
  assign leap_cur       = cdds_pkg::is_leap(year_reg);
  assign len_load       = cdds_pkg::month_len(load_month, leap_load);
  assign len_cur        = cdds_pkg::month_len(month_reg, leap_cur);
  assign prev_month     = 4'(month_reg - 4'd1);
  assign len_prev_month = cdds_pkg::month_len(prev_month, leap_cur);

  // out of range months give a zero length, so the day check rejects them too
  assign load_ok = (load_month >= 4'd1) && (load_month <= 4'd12) &&
                   (load_year != 16'sd0) && (load_day >= 5'd1) &&
                   (load_day <= len_load);

  always_comb begin
    day_next   = day_reg;
    month_next = month_reg;
    year_next  = year_reg;
    st_next    = cdds_pkg::ST_OK;
    unique case (command)
      cdds_pkg::CMD_LOAD: begin
        if (load_ok) begin
          day_next   = load_day;
          month_next = load_month;
          year_next  = load_year;
        end else begin
          st_next = cdds_pkg::ST_BAD_LOAD;
        end
      end
      cdds_pkg::CMD_NEXT: begin
        priority if (day_reg < len_cur) begin
          day_next = 5'(day_reg + 5'd1);
        end else if (month_reg < cdds_pkg::MONTH_DEC) begin
          day_next   = 5'd1;
          month_next = 4'(month_reg + 4'd1);
        end else if (year_reg == cdds_pkg::YEAR_MAX) begin
          st_next = cdds_pkg::ST_LIMIT;
        end else begin
          day_next   = 5'd1;
          month_next = cdds_pkg::MONTH_JAN;
          year_next  = (year_reg == -16'sd1) ? 16'sd1 : year_reg + 16'sd1;
        end
      end
      cdds_pkg::CMD_PREV: begin
        priority if (day_reg > 5'd1) begin
          day_next = 5'(day_reg - 5'd1);
        end else if (month_reg > cdds_pkg::MONTH_JAN) begin
          month_next = prev_month;
          day_next   = len_prev_month;
        end else if (year_reg == cdds_pkg::YEAR_MIN) begin
          st_next = cdds_pkg::ST_LIMIT;
        end else begin
          // december always has 31 days, no leap test for the new year
          month_next = cdds_pkg::MONTH_DEC;
          day_next   = 5'd31;
          year_next  = (year_reg == 16'sd1) ? -16'sd1 : year_reg - 16'sd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res = '{day: day_next, month: month_next, year: year_next, status: st_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= cdds_pkg::RESET_DAY;
      month_reg <= cdds_pkg::RESET_MONTH;
      year_reg  <= cdds_pkg::RESET_YEAR;
    end else if (accept) begin
      day_reg   <= day_next;
      month_reg <= month_next;
      year_reg  <= year_next;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept) skid_word <= res;
    end else if (skid_valid) begin
      out_word <= skid_word;
    end else if (accept) begin
      out_word <= res;
    end
  end

  assign cur_day   = out_word.day;
  assign cur_month = out_word.month;
  assign cur_year  = out_word.year;
  assign status    = out_word.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output word");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (month_reg >= 4'd1) && (month_reg <= 4'd12) && (day_reg >= 5'd1))
    else $error("stored date out of range");

  a_year_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_year != 16'sd0))
    else $error("year zero on output");

  a_held_on_error: assert property (@(posedge clk) disable iff (rst)
    (accept && (st_next != cdds_pkg::ST_OK)) |=>
      (day_reg == $past(day_reg)) && (month_reg == $past(month_reg)) &&
      (year_reg == $past(year_reg)))
    else $error("date changed on a rejected command");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (!skid_valid && out_valid))
    else $error("skid entry not moved to output");

endmodule

### tb/tb_calendar_date_day_stepper.sv
// testbench for the calendar date stepper: random and directed command words, scoreboard check
module tb_calendar_date_day_stepper;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS   = 1250;

  typedef struct {
    cdds_pkg::day_t    day;
    cdds_pkg::month_t  month;
    cdds_pkg::year_t   year;
    cdds_pkg::status_t st;
  } date_word_t;

  class date_scoreboard;
    cdds_pkg::day_t   day;
    cdds_pkg::month_t month;
    cdds_pkg::year_t  year;
    date_word_t       pending_dates[$];
    int               fails;

    function new();
      day   = cdds_pkg::RESET_DAY;
      month = cdds_pkg::RESET_MONTH;
      year  = cdds_pkg::RESET_YEAR;
      fails = 0;
    endfunction

    // years before 1 ad move up by one, so 1 bc is leap
    function int feb_days(cdds_pkg::year_t y);
      int v;
      v = y;
      if (v < 1) v = v + 1;
      if (v % 400 == 0) return 29;
      if (v % 100 == 0) return 28;
      if (v % 4 == 0) return 29;
      return 28;
    endfunction

    function int month_days(cdds_pkg::month_t m, cdds_pkg::year_t y);
      case (m)
        4'd2:                      return feb_days(y);
        4'd4, 4'd6, 4'd9, 4'd11:   return 30;
        default:                   return 31;
      endcase
    endfunction

    // apply one command to the date and queue the word it should produce
    function void note_input(cdds_pkg::cmd_t cmd, cdds_pkg::day_t ld, cdds_pkg::month_t lm,
                             cdds_pkg::year_t ly);
      date_word_t        w;
      cdds_pkg::status_t st;
      st = cdds_pkg::ST_OK;
      case (cmd)
        cdds_pkg::CMD_LOAD: begin
          if (lm >= cdds_pkg::MONTH_JAN && lm <= cdds_pkg::MONTH_DEC && ly != 16'sd0 &&
              ld >= 5'd1 && int'(ld) <= month_days(lm, ly)) begin
            day   = ld;
            month = lm;
            year  = ly;
          end else begin
            st = cdds_pkg::ST_BAD_LOAD;
          end
        end
        cdds_pkg::CMD_NEXT: begin
          if (int'(day) < month_days(month, year)) begin
            day = day + 5'd1;
          end else if (month < cdds_pkg::MONTH_DEC) begin
            day   = 5'd1;
            month = month + 4'd1;
          end else if (year >= cdds_pkg::YEAR_MAX) begin
            st = cdds_pkg::ST_LIMIT;
          end else begin
            day   = 5'd1;
            month = cdds_pkg::MONTH_JAN;
            year  = (year == -16'sd1) ? 16'sd1 : year + 16'sd1;
          end
        end
        cdds_pkg::CMD_PREV: begin
          if (day > 5'd1) begin
            day = day - 5'd1;
          end else if (month > cdds_pkg::MONTH_JAN) begin
            month = month - 4'd1;
            day   = cdds_pkg::day_t'(month_days(month, year));
          end else if (year <= cdds_pkg::YEAR_MIN) begin
            st = cdds_pkg::ST_LIMIT;
          end else begin
            month = cdds_pkg::MONTH_DEC;
            year  = (year == 16'sd1) ? -16'sd1 : year - 16'sd1;
            day   = cdds_pkg::day_t'(month_days(month, year));
          end
        end
        default: ;
      endcase
      w.day   = day;
      w.month = month;
      w.year  = year;
      w.st    = st;
      pending_dates.push_back(w);
    endfunction

    function void check_result(cdds_pkg::day_t d, cdds_pkg::month_t m, cdds_pkg::year_t y,
                               cdds_pkg::status_t s);
      date_word_t e;
      if (pending_dates.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result word %0d/%0d/%0d status %0d", d, m, y, s);
        return;
      end
      e = pending_dates.pop_front();
      if (e.day !== d || e.month !== m || e.year !== y || e.st !== s) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                   e.day, e.month, e.year, e.st, d, m, y, s);
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  cdds_pkg::cmd_t    command    = cdds_pkg::CMD_NONE;
  cdds_pkg::day_t    load_day   = '0;
  cdds_pkg::month_t  load_month = '0;
  cdds_pkg::year_t   load_year  = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  cdds_pkg::day_t    cur_day;
  cdds_pkg::month_t  cur_month;
  cdds_pkg::year_t   cur_year;
  cdds_pkg::status_t status;

  date_scoreboard sb = new();
  int words_sent = 0;
  int calm_in    = 0;
  int idle_count = 0;

  calendar_date_day_stepper dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .load_day   (load_day),
    .load_month (load_month),
    .load_year  (load_year),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cur_day    (cur_day),
    .cur_month  (cur_month),
    .cur_year   (cur_year),
    .status     (status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_input(command, load_day, load_month, load_year);
    if (!rst && out_valid && !out_stall)
      sb.check_result(cur_day, cur_month, cur_year, status);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // output back-pressure: short stalls, a few long ones, long free stretches
  initial begin
    int r;
    int span;
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 8);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 3);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        span = $urandom_range(15, 60);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(50, 200);
      end
      repeat (span) @(posedge clk);
    end
  end

  function automatic int next_in_gap();
    int r;
    if (calm_in > 0) begin
      calm_in--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_in = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one word, hold it until taken, then maybe leave a gap
  task automatic send_word(cdds_pkg::cmd_t c, cdds_pkg::day_t d, cdds_pkg::month_t m,
                           cdds_pkg::year_t y);
    int gap;
    in_valid   <= 1'b1;
    command    <= c;
    load_day   <= d;
    load_month <= m;
    load_year  <= y;
    do @(posedge clk); while (in_stall);
    words_sent++;
    gap = next_in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_step(cdds_pkg::cmd_t c);
    send_word(c, cdds_pkg::day_t'($urandom), cdds_pkg::month_t'($urandom),
              cdds_pkg::year_t'($urandom));
  endtask

  function automatic cdds_pkg::year_t pick_year();
    int v;
    case ($urandom_range(0, 9))
      0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
      2:       v = 32767 - int'($urandom_range(0, 2));
      3:       v = -32768 + int'($urandom_range(0, 2));
      4, 5:    v = int'($urandom_range(0, 8)) - 4;
      6, 7: begin
        // century years, and bc years whose shifted value is a century
        v = 100 * int'($urandom_range(0, 640)) - 32000;
        if ($urandom_range(0, 1)) v = v - 1;
      end
      default: begin
        v = int'($urandom_range(1, 2400));
        if ($urandom_range(0, 3) == 0) v = -v;
      end
    endcase
    if (v == 0) v = 1;
    return cdds_pkg::year_t'(v);
  endfunction

  task automatic load_valid_date();
    cdds_pkg::month_t m;
    cdds_pkg::year_t  y;
    int               len;
    int               d;
    m   = cdds_pkg::month_t'($urandom_range(1, 12));
    y   = pick_year();
    len = sb.month_days(m, y);
    case ($urandom_range(0, 4))
      0, 1:    d = len - int'($urandom_range(0, 2));
      2:       d = 1;
      default: d = int'($urandom_range(1, len));
    endcase
    send_word(cdds_pkg::CMD_LOAD, cdds_pkg::day_t'(d), m, y);
  endtask

  task automatic walk_dates();
    int n;
    int mode;
    n    = $urandom_range(1, 40);
    mode = $urandom_range(0, 2);
    repeat (n) begin
      if (mode == 0) send_step(cdds_pkg::CMD_NEXT);
      else if (mode == 1) send_step(cdds_pkg::CMD_PREV);
      else send_step($urandom_range(0, 1) ? cdds_pkg::CMD_NEXT : cdds_pkg::CMD_PREV);
    end
  endtask

  initial begin
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // leap rules, bad loads and both ends of the year range
    send_step(cdds_pkg::CMD_NEXT);
    send_step(cdds_pkg::CMD_PREV);
    send_word(cdds_pkg::CMD_LOAD, 5'd29, cdds_pkg::MONTH_FEB, 16'sd2000);
    send_word(cdds_pkg::CMD_LOAD, 5'd29, cdds_pkg::MONTH_FEB, 16'sd1900);
    send_word(cdds_pkg::CMD_LOAD, 5'd29, cdds_pkg::MONTH_FEB, 16'sd2023);
    send_word(cdds_pkg::CMD_LOAD, 5'd29, cdds_pkg::MONTH_FEB, -16'sd1);
    send_word(cdds_pkg::CMD_LOAD, 5'd29, cdds_pkg::MONTH_FEB, -16'sd401);
    send_word(cdds_pkg::CMD_LOAD, 5'd28, cdds_pkg::MONTH_FEB, 16'sd2100);
    send_step(cdds_pkg::CMD_NEXT);
    send_step(cdds_pkg::CMD_PREV);
    send_word(cdds_pkg::CMD_LOAD, 5'd0, 4'd5, 16'sd10);
    send_word(cdds_pkg::CMD_LOAD, 5'd31, 4'd4, 16'sd10);
    send_word(cdds_pkg::CMD_LOAD, 5'd1, 4'd0, 16'sd10);
    send_word(cdds_pkg::CMD_LOAD, 5'd1, 4'd13, 16'sd10);
    send_word(cdds_pkg::CMD_LOAD, 5'd31, 4'd15, cdds_pkg::YEAR_MIN);
    send_word(cdds_pkg::CMD_LOAD, 5'd1, cdds_pkg::MONTH_JAN, 16'sd0);
    send_word(cdds_pkg::CMD_LOAD, 5'd31, cdds_pkg::MONTH_DEC, -16'sd1);
    send_step(cdds_pkg::CMD_NEXT);
    send_step(cdds_pkg::CMD_PREV);
    send_word(cdds_pkg::CMD_LOAD, 5'd31, cdds_pkg::MONTH_DEC, cdds_pkg::YEAR_MAX);
    send_step(cdds_pkg::CMD_NEXT);
    send_word(cdds_pkg::CMD_LOAD, 5'd1, cdds_pkg::MONTH_JAN, cdds_pkg::YEAR_MIN);
    send_step(cdds_pkg::CMD_PREV);
    send_word(cdds_pkg::CMD_NONE, 5'd31, 4'd15, cdds_pkg::YEAR_MAX);
    send_step(cdds_pkg::CMD_NEXT);

    r = words_sent;
    while (words_sent < r + RANDOM_WORDS) begin
      case ($urandom_range(0, 19))
        0, 1:
          send_word(cdds_pkg::CMD_LOAD, cdds_pkg::day_t'($urandom),
                    cdds_pkg::month_t'($urandom), cdds_pkg::year_t'($urandom));
        2, 3, 4, 5, 6: begin
          load_valid_date();
          walk_dates();
        end
        19:      send_step(cdds_pkg::CMD_NONE);
        default: walk_dates();
      endcase
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
